FILE: rtl/generational_handle_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GHA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");

// Next-cycle implication, checked outside reset.
`define GHA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");

`endif

FILE: rtl/gha_pkg.sv
`default_nettype none

package gha_pkg;

	localparam int CAPACITY = 4096;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;
	localparam int VER_W    = 32;

	localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
	localparam logic [VER_W-1:0] VER_ONE = VER_W'(1);

	localparam logic MODE_CREATE = 1'b0;
	localparam logic MODE_FREE   = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_VER
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/generational_handle_allocator.sv
// No stall input. A free or a create of a never-used slot goes via S_VER before
// done strobes; a create that pops the free stack goes via S_POP, then S_VER; a
// rejected free or a full create strobes done from S_IDLE. Start waits for S_IDLE,
// as the version memory's read-modify-write uses its single synchronous read port.
// Reset clears state, done and counters only; entries at or above the never-used
// count read as zero; no clearing pass runs and start is taken right after reset.
`default_nettype none

`include "generational_handle_allocator_assert.svh"

module generational_handle_allocator
	import gha_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             mode,
	input  wire logic [IDX_W-1:0] given_index,
	input  wire logic [VER_W-1:0] given_version,
	output logic                  done,
	output logic [1:0]            status,
	output logic [IDX_W-1:0]      handle_index,
	output logic [VER_W-1:0]      handle_version
);

	logic [VER_W-1:0] ver_mem [CAPACITY];
	logic [IDX_W-1:0] stk_mem [CAPACITY];

	state_t state_q, state_d;

	logic [CNT_W-1:0] next_unused_q;
	logic [CNT_W-1:0] free_count_q;
	logic             mode_q;
	logic [IDX_W-1:0] slot_q;
	logic [VER_W-1:0] gver_q;

	logic [VER_W-1:0] ver_rd_s1;
	logic             ver_vld_s1;
	logic [IDX_W-1:0] stk_rd_s1;

	logic             accept;
	logic             free_bad;
	logic [VER_W-1:0] stored_ver;
	logic [VER_W-1:0] bumped_ver;
	logic [VER_W-1:0] fresh_ver;

	// control decoded from the state
	logic             ver_rd_en;
	logic [IDX_W-1:0] ver_rd_addr;
	logic             ver_wr_en;
	logic [VER_W-1:0] ver_wr_data;
	logic             stk_rd_en;
	logic             stk_wr_en;
	logic             slot_ld;
	logic [IDX_W-1:0] slot_d;
	logic             nu_inc;
	logic             fc_dec;
	logic             fc_inc;
	logic             res_en;
	status_t          res_status;
	logic [IDX_W-1:0] res_index;
	logic [VER_W-1:0] res_version;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign free_bad = (given_version == '0) || (free_count_q >= CAP_C) ||
		({1'b0, given_index} >= CAP_C);

	// entries at or above the never-used count were never written: read as zero
	assign stored_ver = ver_vld_s1 ? ver_rd_s1 : '0;
	assign fresh_ver  = (stored_ver == '0) ? VER_ONE : stored_ver;
	assign bumped_ver = ((gver_q + VER_ONE) == '0) ? VER_ONE : (gver_q + VER_ONE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == MODE_CREATE) begin
						if (next_unused_q < CAP_C) begin
							state_d = S_VER;
						end else if (free_count_q != '0) begin
							state_d = S_POP;
						end
					end else if (!free_bad) begin
						state_d = S_VER;
					end
				end
			end
			S_POP:   state_d = S_VER;
			S_VER:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ver_rd_en   = 1'b0;
		ver_rd_addr = slot_q;
		ver_wr_en   = 1'b0;
		ver_wr_data = fresh_ver;
		stk_rd_en   = 1'b0;
		stk_wr_en   = 1'b0;
		slot_ld     = 1'b0;
		slot_d      = given_index;
		nu_inc      = 1'b0;
		fc_dec      = 1'b0;
		fc_inc      = 1'b0;
		res_en      = 1'b0;
		res_status  = ST_OK;
		res_index   = '0;
		res_version = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == MODE_CREATE) begin
						if (next_unused_q < CAP_C) begin
							slot_ld     = 1'b1;
							slot_d      = next_unused_q[IDX_W-1:0];
							ver_rd_en   = 1'b1;
							ver_rd_addr = next_unused_q[IDX_W-1:0];
							nu_inc      = 1'b1;
						end else if (free_count_q != '0) begin
							stk_rd_en = 1'b1;
							fc_dec    = 1'b1;
						end else begin
							res_en     = 1'b1;
							res_status = ST_FULL;
						end
					end else if (free_bad) begin
						res_en     = 1'b1;
						res_status = ST_REJECT;
					end else begin
						slot_ld     = 1'b1;
						ver_rd_en   = 1'b1;
						ver_rd_addr = given_index;
					end
				end
			end
			S_POP: begin
				slot_ld     = 1'b1;
				slot_d      = stk_rd_s1;
				ver_rd_en   = 1'b1;
				ver_rd_addr = stk_rd_s1;
			end
			S_VER: begin
				res_en = 1'b1;
				if (mode_q == MODE_CREATE) begin
					ver_wr_en   = 1'b1;
					ver_wr_data = fresh_ver;
					res_index   = slot_q;
					res_version = fresh_ver;
				end else if (stored_ver != gver_q) begin
					res_status = ST_REJECT;
				end else begin
					ver_wr_en   = 1'b1;
					ver_wr_data = bumped_ver;
					stk_wr_en   = 1'b1;
					fc_inc      = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			next_unused_q <= '0;
			free_count_q  <= '0;
			done          <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= res_en;
			if (nu_inc) begin
				next_unused_q <= next_unused_q + CNT_W'(1);
			end
			if (fc_dec) begin
				free_count_q <= free_count_q - CNT_W'(1);
			end else if (fc_inc) begin
				free_count_q <= free_count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			gver_q <= given_version;
		end
		if (slot_ld) begin
			slot_q <= slot_d;
		end
		if (res_en) begin
			status         <= res_status;
			handle_index   <= res_index;
			handle_version <= res_version;
		end
	end

	// version memory: one read port, one write port
	always_ff @(posedge clk) begin
		if (ver_wr_en) begin
			ver_mem[slot_q] <= ver_wr_data;
		end
		if (ver_rd_en) begin
			ver_rd_s1  <= ver_mem[ver_rd_addr];
			ver_vld_s1 <= ({1'b0, ver_rd_addr} < next_unused_q);
		end
	end

	// free stack: pop reads below the count, push writes at the count
	always_ff @(posedge clk) begin
		if (stk_wr_en) begin
			stk_mem[free_count_q[IDX_W-1:0]] <= slot_q;
		end
		if (stk_rd_en) begin
			stk_rd_s1 <= stk_mem[free_count_q[IDX_W-1:0] - IDX_W'(1)];
		end
	end

	`GHA_ASSERT_IMP(a_done_idle, done, !busy)
	`GHA_ASSERT_IMP(a_fc_bound, 1'b1, free_count_q <= CAP_C)
	`GHA_ASSERT_NXT(a_accept_progress, accept, busy || done)
	`GHA_ASSERT_NXT(a_fresh_slot, accept && mode == MODE_CREATE && next_unused_q < CAP_C,
		next_unused_q == $past(next_unused_q) + CNT_W'(1))
	`GHA_ASSERT_IMP(a_fail_zero, done && status != ST_OK,
		handle_index == '0 && handle_version == '0)

endmodule

`default_nettype wire
